FILE: sv/open_address_hash_table_top_assert.svh
// ----------------------------------------------------------------------------
// open_address_hash_table_top_assert.svh
// Assertion macros shared by the hash table checker.
// ----------------------------------------------------------------------------
`ifndef OPEN_ADDRESS_HASH_TABLE_TOP_ASSERT_SVH
`define OPEN_ADDRESS_HASH_TABLE_TOP_ASSERT_SVH

// Same-cycle implication under clk, disabled while reset is held
`define OAHT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hash table check failed");

// Next-cycle implication under clk, disabled while reset is held
`define OAHT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hash table check failed");

`endif

FILE: sv/oaht_pkg.sv
// ----------------------------------------------------------------------------
// oaht_pkg
// Types, codes and helpers for the open-addressing hash table.
// ----------------------------------------------------------------------------
package oaht_pkg;

    localparam int OAHT_DEPTH = 1024;
    localparam int SIZE_W     = 11;
    localparam int DATA_W     = 32;
    localparam int NBITS_W    = 6;

    typedef enum logic [1:0] {
        CMD_SEARCH = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_ERASE  = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SLOT_EMPTY   = 2'd0,
        SLOT_USED    = 2'd1,
        SLOT_DELETED = 2'd2
    } slot_state_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV_HOME,
        S_DIV_STEP,
        S_DIV_C17,
        S_DIV_C31,
        S_FIND_RD,
        S_FIND_CHK,
        S_INS_RD,
        S_INS_CHK,
        S_DONE
    } fsm_t;

    typedef struct packed {
        logic [1:0]               command;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] found_value;
        logic [SIZE_W-1:0]        probe_count;
        logic [SIZE_W-1:0]        item_count;
        logic [DATA_W-1:0]        collision_total;
    } out_item_t;

    typedef struct packed {
        slot_state_t       state;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] value;
    } slot_t;

    // Request to the shared remainder unit
    typedef struct packed {
        logic               start;
        logic [DATA_W-1:0]  dividend;
        logic [NBITS_W-1:0] nbits;
        logic [SIZE_W-1:0]  divisor;
    } mod_req_t;

    // Response from the shared remainder unit
    typedef struct packed {
        logic              done;
        logic [SIZE_W-1:0] rem;
    } mod_rsp_t;

    // Add two residues below m and reduce once
    function automatic logic [SIZE_W-1:0] mod_add(
        input logic [SIZE_W-1:0] a,
        input logic [SIZE_W-1:0] b,
        input logic [SIZE_W-1:0] m
    );
        logic [SIZE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m})
        begin
            s = s - {1'b0, m};
        end
        return s[SIZE_W-1:0];
    endfunction

endpackage

FILE: sv/oaht_ram.sv
// ----------------------------------------------------------------------------
// oaht_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module oaht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: sv/oaht_mod_unit.sv
// ----------------------------------------------------------------------------
// oaht_mod_unit
// Bit-serial remainder unit: one dividend bit per cycle, restoring form.
// ----------------------------------------------------------------------------
module oaht_mod_unit
    import oaht_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mod_req_t req,
    output mod_rsp_t rsp
);

    logic [DATA_W-1:0]  dvd_reg;
    logic [SIZE_W-1:0]  rem_reg;
    logic [SIZE_W-1:0]  div_reg;
    logic [NBITS_W-1:0] cnt_reg;
    logic               run_reg;
    logic               done_reg;
    logic [SIZE_W:0]    trial;
    logic [SIZE_W:0]    reduced;

    // Shift in the next bit and subtract when it fits
    always_comb
    begin
        trial   = {rem_reg, dvd_reg[DATA_W-1]};
        reduced = trial;
        if (trial >= {1'b0, div_reg})
        begin
            reduced = trial - {1'b0, div_reg};
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= req.nbits;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == NBITS_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend << (NBITS_W'(DATA_W) - req.nbits);
            div_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= reduced[SIZE_W-1:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

FILE: sv/open_address_hash_table_top.sv
// ----------------------------------------------------------------------------
// open_address_hash_table_top
// Open-addressing key/value table with tombstones, double or custom probing.
// ----------------------------------------------------------------------------
// After reset the block sweeps the slot memory, marking every slot empty,
// and takes no item meanwhile (configuration writes are taken). Each
// command then runs on its own: acceptance in idle, a bit-serial remainder
// unit that computes home and step, and in custom probing mode two more
// reductions, then a read state and a check state per slot visited, since
// the slot memory read is registered, and a done state that posts the
// result and waits there while the previous result sits before a stalled
// receiver. A NOP skips the remainder unit and the walk. An insert that
// misses walks twice. Probe positions advance by modular adds, so no
// division runs in the walk.
// ----------------------------------------------------------------------------
module open_address_hash_table_top
    import oaht_pkg::*;
#(
    parameter int DEPTH = OAHT_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_item,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [SIZE_W-1:0] cfg_data
);

    localparam int AW        = $clog2(DEPTH);
    localparam int LW        = $clog2(DEPTH + 1);
    localparam int DEPTH_CAP = (DEPTH > 2047) ? 2047 : DEPTH;
    localparam logic [SIZE_W-1:0] M_MAX = SIZE_W'(DEPTH_CAP);
    localparam logic [SIZE_W-1:0] M_MIN = SIZE_W'(2);
    localparam logic [AW-1:0]     CLR_LAST = AW'(DEPTH - 1);

    fsm_t state_reg, state_next;

    // Configuration
    logic              mode_cfg_reg;
    logic [SIZE_W-1:0] size_cfg_reg;
    logic [SIZE_W-1:0] m_eff;

    // Command context
    logic [1:0]        cmd_reg;
    logic [DATA_W-1:0] key_reg;
    logic [DATA_W-1:0] val_reg;
    logic [SIZE_W-1:0] m_reg;
    logic              mode_reg;

    // Walk state
    logic [SIZE_W-1:0] home_reg;
    logic [SIZE_W-1:0] step_reg;
    logic [SIZE_W-1:0] c17_reg;
    logic [SIZE_W-1:0] d0_reg;
    logic [SIZE_W-1:0] d_reg;
    logic [SIZE_W-1:0] dinc_reg;
    logic [SIZE_W-1:0] pos_reg;
    logic [SIZE_W-1:0] cnt_reg;

    // Result and running counts
    logic [1:0]        res_status_reg;
    logic [DATA_W-1:0] res_found_reg;
    logic [SIZE_W-1:0] res_probes_reg;
    logic [LW-1:0]     live_reg;
    logic [DATA_W-1:0] coll_reg;
    logic              out_valid_reg;
    out_item_t         out_reg;

    logic [AW-1:0]     clr_reg;
    logic              div_pend_reg;

    // Memory and remainder unit hookup
    logic              ram_we;
    logic [AW-1:0]     ram_wr_addr;
    slot_t             ram_wr_data;
    logic              ram_rd_en;
    logic [AW-1:0]     ram_rd_addr;
    slot_t             ram_rd_data;
    mod_req_t          div_req;
    mod_rsp_t          div_rsp;

    // Derived values
    logic              in_take;
    logic              out_free;
    logic              hit;
    logic              last_probe;
    logic [SIZE_W-1:0] cnt_inc;
    logic [SIZE_W-1:0] pos_adv;
    logic [SIZE_W-1:0] d_adv;
    logic [SIZE_W-1:0] step_new;
    logic [15:0]       step17;

    oaht_ram #(
        .WIDTH ($bits(slot_t)),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    oaht_mod_unit u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Clamp the configured size to the usable range
    always_comb
    begin
        m_eff = size_cfg_reg;
        if (size_cfg_reg < M_MIN)
        begin
            m_eff = M_MIN;
        end
        else if (size_cfg_reg > M_MAX)
        begin
            m_eff = M_MAX;
        end
    end

    assign in_take    = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign hit        = (ram_rd_data.state == SLOT_USED) && (ram_rd_data.key == key_reg);
    assign cnt_inc    = cnt_reg + 1'b1;
    assign last_probe = (cnt_inc == m_reg);
    assign pos_adv    = mod_add(pos_reg, d_reg, m_reg);
    assign d_adv      = mod_add(d_reg, dinc_reg, m_reg);
    assign step_new   = div_rsp.rem + 1'b1;
    assign step17     = 16'(step_reg) * 16'd17;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_take)
                begin
                    if (in_item.command == CMD_NOP)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_DIV_HOME;
                    end
                end
            end
            S_DIV_HOME:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_DIV_STEP;
                end
            end
            S_DIV_STEP:
            begin
                if (div_rsp.done)
                begin
                    state_next = mode_reg ? S_DIV_C17 : S_FIND_RD;
                end
            end
            S_DIV_C17:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_DIV_C31;
                end
            end
            S_DIV_C31:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_FIND_RD;
                end
            end
            S_FIND_RD:
            begin
                state_next = S_FIND_CHK;
            end
            S_FIND_CHK:
            begin
                if (hit)
                begin
                    state_next = S_DONE;
                end
                else if ((ram_rd_data.state == SLOT_EMPTY) || last_probe)
                begin
                    state_next = (cmd_reg == CMD_INSERT) ? S_INS_RD : S_DONE;
                end
                else
                begin
                    state_next = S_FIND_RD;
                end
            end
            S_INS_RD:
            begin
                state_next = S_INS_CHK;
            end
            S_INS_CHK:
            begin
                if ((ram_rd_data.state != SLOT_USED) || last_probe)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_INS_RD;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer: memory and remainder unit controls
    always_comb
    begin
        in_stall         = (state_reg != S_IDLE);
        ram_rd_en        = (state_reg == S_FIND_RD) || (state_reg == S_INS_RD);
        ram_rd_addr      = AW'(pos_reg);
        ram_we           = 1'b0;
        ram_wr_addr      = AW'(pos_reg);
        ram_wr_data      = ram_rd_data;
        div_req.start    = 1'b0;
        div_req.dividend = key_reg;
        div_req.nbits    = NBITS_W'(DATA_W);
        div_req.divisor  = m_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we            = 1'b1;
                ram_wr_addr       = clr_reg;
                ram_wr_data.state = SLOT_EMPTY;
                ram_wr_data.key   = '0;
                ram_wr_data.value = '0;
            end
            S_DIV_HOME:
            begin
                div_req.start = !div_pend_reg;
            end
            S_DIV_STEP:
            begin
                div_req.start    = !div_pend_reg;
                div_req.dividend = DATA_W'(key_reg[DATA_W-1:16]);
                div_req.nbits    = NBITS_W'(16);
                div_req.divisor  = m_reg - 1'b1;
            end
            S_DIV_C17:
            begin
                div_req.start    = !div_pend_reg;
                div_req.dividend = DATA_W'(step17);
                div_req.nbits    = NBITS_W'(16);
            end
            S_DIV_C31:
            begin
                div_req.start    = !div_pend_reg;
                div_req.dividend = DATA_W'(31);
                div_req.nbits    = NBITS_W'(5);
            end
            S_FIND_CHK:
            begin
                // Erase leaves a tombstone over the matching slot
                if (hit && (cmd_reg == CMD_ERASE))
                begin
                    ram_we            = 1'b1;
                    ram_wr_data.state = SLOT_DELETED;
                end
            end
            S_INS_CHK:
            begin
                if (ram_rd_data.state != SLOT_USED)
                begin
                    ram_we            = 1'b1;
                    ram_wr_data.state = SLOT_USED;
                    ram_wr_data.key   = key_reg;
                    ram_wr_data.value = val_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            mode_cfg_reg  <= 1'b0;
            size_cfg_reg  <= SIZE_W'(13);
            live_reg      <= '0;
            coll_reg      <= '0;
            out_valid_reg <= 1'b0;
            div_pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Configuration writes
            if (cfg_we)
            begin
                if (cfg_index)
                begin
                    size_cfg_reg <= cfg_data;
                end
                else
                begin
                    mode_cfg_reg <= cfg_data[0];
                end
            end

            // Advance the clearing sweep
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end

            // Track an outstanding remainder request
            if (div_req.start)
            begin
                div_pend_reg <= 1'b1;
            end
            else if (div_rsp.done)
            begin
                div_pend_reg <= 1'b0;
            end

            // Running counts
            if ((state_reg == S_FIND_CHK) && hit && (cmd_reg == CMD_ERASE) && (live_reg != '0))
            begin
                live_reg <= live_reg - 1'b1;
            end
            if (state_reg == S_INS_CHK)
            begin
                if (ram_rd_data.state != SLOT_USED)
                begin
                    live_reg <= live_reg + 1'b1;
                end
                else if (coll_reg != '1)
                begin
                    coll_reg <= coll_reg + 1'b1;
                end
            end

            // Output register: load a new item or drop the taken one
            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    cmd_reg        <= in_item.command;
                    key_reg        <= in_item.key;
                    val_reg        <= in_item.value;
                    m_reg          <= m_eff;
                    mode_reg       <= mode_cfg_reg;
                    res_status_reg <= ST_DONE;
                    res_found_reg  <= '0;
                    res_probes_reg <= '0;
                end
            end
            S_DIV_HOME:
            begin
                if (div_rsp.done)
                begin
                    home_reg <= div_rsp.rem;
                end
            end
            S_DIV_STEP:
            begin
                if (div_rsp.done)
                begin
                    step_reg <= step_new;
                    d0_reg   <= step_new;
                    d_reg    <= step_new;
                    dinc_reg <= '0;
                    pos_reg  <= home_reg;
                    cnt_reg  <= '0;
                end
            end
            S_DIV_C17:
            begin
                if (div_rsp.done)
                begin
                    c17_reg <= div_rsp.rem;
                end
            end
            S_DIV_C31:
            begin
                // First gap 17*step + 31, then each gap grows by 62
                if (div_rsp.done)
                begin
                    d0_reg   <= mod_add(c17_reg, div_rsp.rem, m_reg);
                    d_reg    <= mod_add(c17_reg, div_rsp.rem, m_reg);
                    dinc_reg <= mod_add(div_rsp.rem, div_rsp.rem, m_reg);
                end
            end
            S_FIND_CHK:
            begin
                res_probes_reg <= cnt_inc;
                if (hit)
                begin
                    if (cmd_reg == CMD_SEARCH)
                    begin
                        res_found_reg <= ram_rd_data.value;
                    end
                    else if (cmd_reg == CMD_INSERT)
                    begin
                        res_status_reg <= ST_DUPLICATE;
                    end
                end
                else if ((ram_rd_data.state == SLOT_EMPTY) || last_probe)
                begin
                    // Miss: restart the walk for the fill pass of an insert
                    if (cmd_reg != CMD_INSERT)
                    begin
                        res_status_reg <= ST_NOT_FOUND;
                    end
                    pos_reg <= home_reg;
                    d_reg   <= d0_reg;
                    cnt_reg <= '0;
                end
                else
                begin
                    cnt_reg <= cnt_inc;
                    pos_reg <= pos_adv;
                    d_reg   <= d_adv;
                end
            end
            S_INS_CHK:
            begin
                cnt_reg <= cnt_inc;
                pos_reg <= pos_adv;
                d_reg   <= d_adv;
                if ((ram_rd_data.state == SLOT_USED) && last_probe)
                begin
                    res_status_reg <= ST_FULL;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_reg.status          <= res_status_reg;
                    out_reg.found_value     <= res_found_reg;
                    out_reg.probe_count     <= res_probes_reg;
                    out_reg.item_count      <= SIZE_W'(live_reg);
                    out_reg.collision_total <= coll_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

FILE: sv/oaht_checker.sv
// ----------------------------------------------------------------------------
// oaht_checker
// Port-level checks on the hash table, bound to the top level.
// ----------------------------------------------------------------------------
`include "open_address_hash_table_top_assert.svh"

module oaht_port_checker
    import oaht_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input out_item_t out_item,
    input logic      out_valid,
    input logic      out_stall
);

    logic failed_result;
    logic walked_result;

    assign failed_result = out_valid && (out_item.status != ST_DONE);
    assign walked_result = out_valid &&
                           ((out_item.status == ST_DUPLICATE) || (out_item.status == ST_FULL));

    // A result waiting on a stalled receiver stays offered
    `OAHT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

    // Every command keeps the block busy for at least the next cycle
    `OAHT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

    // A failed command returns no value
    `OAHT_ASSERT_NOW(a_found_zero, failed_result, out_item.found_value == '0)

    // Duplicate and full outcomes always come from a walk
    `OAHT_ASSERT_NOW(a_walked, walked_result, out_item.probe_count != '0)

endmodule

bind open_address_hash_table_top oaht_port_checker u_oaht_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_item  (out_item),
    .out_valid (out_valid),
    .out_stall (out_stall)
);

FILE: verif/oaht_checker.sv
// ----------------------------------------------------------------------------
// oaht_checker
// Predicts each result of the hash table from accepted commands and compares.
// ----------------------------------------------------------------------------
// Keeps its own copy of the slot array and counters. Configuration writes are
// applied as seen on the write port; the bench writes only while idle.
// ----------------------------------------------------------------------------
module oaht_checker
    import oaht_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  in_item_t          in_item,
    input  logic              out_valid,
    input  logic              out_stall,
    input  out_item_t         out_item,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [SIZE_W-1:0] cfg_data,
    output int                fail_count,
    output int                pending
);

    localparam logic CFG_MODE = 1'b0;
    localparam logic CFG_SIZE = 1'b1;
    localparam int   EXP_DEPTH = 8;

    slot_state_t       tbl_state [OAHT_DEPTH];
    logic [DATA_W-1:0] tbl_key   [OAHT_DEPTH];
    logic [DATA_W-1:0] tbl_value [OAHT_DEPTH];
    logic [SIZE_W-1:0] live_keys;
    logic [DATA_W-1:0] collisions;
    logic              mode_q;
    logic [SIZE_W-1:0] size_q;
    out_item_t         exp_fifo [EXP_DEPTH];
    logic [2:0]        exp_rd_ptr;
    logic [2:0]        exp_wr_ptr;
    int                exp_count;

    assign pending = exp_count;

    // Slot visited by probe i for hash h and size m
    function automatic int unsigned probe_at(logic [31:0] h, int unsigned i,
                                             int unsigned m);
        longint unsigned home, stride, pos;
        home   = h % m;
        stride = 1 + ((h >> 16) % (m - 1));
        if (mode_q == 1'b0)
            pos = home + i * stride;
        else
            pos = home + 17 * i * stride + 31 * longint'(i) * i;
        return 32'(pos % m);
    endfunction

    // Walk until the key or an empty slot; -1 if absent
    function automatic int locate(logic [31:0] k, int unsigned m, output int probes);
        int unsigned p;
        probes = 0;
        for (int unsigned i = 0; i < m; i++)
        begin
            p = probe_at(k, i, m);
            probes++;
            if (tbl_state[p] == SLOT_EMPTY)
                return -1;
            if (tbl_state[p] == SLOT_USED && tbl_key[p] == k)
                return int'(p);
        end
        return -1;
    endfunction

    // Apply one command to the shadow table and return its result
    function automatic out_item_t apply_command(in_item_t it);
        out_item_t   r;
        int unsigned m, p;
        int          at, probes;
        logic [31:0] k;
        bit          stored;
        r = '0;
        probes = 0;
        k = it.key;
        m = size_q < 2 ? 2 : (size_q > OAHT_DEPTH ? OAHT_DEPTH : size_q);
        case (cmd_t'(it.command))
            CMD_SEARCH:
            begin
                at = locate(k, m, probes);
                if (at >= 0)
                    r.found_value = tbl_value[at];
                else
                    r.status = ST_NOT_FOUND;
            end
            CMD_INSERT:
            begin
                at = locate(k, m, probes);
                if (at >= 0)
                    r.status = ST_DUPLICATE;
                else
                begin
                    stored = 0;
                    for (int unsigned i = 0; i < m && !stored; i++)
                    begin
                        p = probe_at(k, i, m);
                        if (tbl_state[p] == SLOT_USED)
                        begin
                            if (collisions != '1)
                                collisions++;
                        end
                        else
                        begin
                            tbl_state[p] = SLOT_USED;
                            tbl_key[p]   = k;
                            tbl_value[p] = it.value;
                            live_keys++;
                            stored = 1;
                        end
                    end
                    if (!stored)
                        r.status = ST_FULL;
                end
            end
            CMD_ERASE:
            begin
                at = locate(k, m, probes);
                if (at >= 0)
                begin
                    tbl_state[at] = SLOT_DELETED;
                    if (live_keys > 0)
                        live_keys--;
                end
                else
                    r.status = ST_NOT_FOUND;
            end
            default: ;
        endcase
        r.probe_count     = SIZE_W'(probes);
        r.item_count      = live_keys;
        r.collision_total = collisions;
        return r;
    endfunction

    // Track config, predict on accept, compare on result
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t exp_item;
        if (!rst_n)
        begin
            for (int i = 0; i < OAHT_DEPTH; i++)
                tbl_state[i] = SLOT_EMPTY;
            live_keys  = '0;
            collisions = '0;
            mode_q     = 1'b0;
            size_q     = 13;
            exp_rd_ptr = '0;
            exp_wr_ptr = '0;
            exp_count  = 0;
            fail_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (exp_count == 0)
                begin
                    $display("%0t: unexpected result %p", $time, out_item);
                    fail_count++;
                end
                else
                begin
                    exp_item   = exp_fifo[exp_rd_ptr];
                    exp_rd_ptr = exp_rd_ptr + 1'b1;
                    exp_count--;
                    if (exp_item !== out_item)
                    begin
                        $display("%0t: mismatch expected %p actual %p",
                                 $time, exp_item, out_item);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (exp_count == EXP_DEPTH)
                begin
                    $display("%0t: too many items in flight", $time);
                    fail_count++;
                end
                else
                begin
                    exp_fifo[exp_wr_ptr] = apply_command(in_item);
                    exp_wr_ptr = exp_wr_ptr + 1'b1;
                    exp_count++;
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_MODE)
                    mode_q = cfg_data[0];
                else if (cfg_index == CFG_SIZE)
                    size_q = cfg_data;
            end
        end
    end

endmodule

FILE: verif/tb_open_address_hash_table_top.sv
// ----------------------------------------------------------------------------
// tb_open_address_hash_table_top
// Random and directed command traffic for the open-addressing hash table.
// ----------------------------------------------------------------------------
// Runs phases under both probe modes and several table sizes; keys come mostly
// from a small per-phase pool so that searches hit, duplicates and erases
// occur and small tables fill up. A checker instance predicts and compares.
// ----------------------------------------------------------------------------
module tb_open_address_hash_table_top;
    import oaht_pkg::*;

    localparam logic CFG_MODE = 1'b0;
    localparam logic CFG_SIZE = 1'b1;
    localparam int   WATCHDOG = 200000;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    in_item_t          in_item;
    logic              out_valid;
    logic              out_stall;
    out_item_t         out_item;
    logic              cfg_we;
    logic              cfg_index;
    logic [SIZE_W-1:0] cfg_data;
    int                fail_count;
    int                pending;
    int                idle_cycles;
    bit                hold_long;
    logic [31:0]       key_pool[16];

    open_address_hash_table_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    oaht_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Mostly short gaps, a few long ones
    function automatic int gap_len();
        if ($urandom_range(0, 9) < 4)
            return 0;
        if ($urandom_range(0, 19) != 0)
            return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    // Stall the result side at random; one long hold-off on request
    initial
    begin
        int n;
        bit long_done;
        out_stall = 1'b0;
        long_done = 0;
        @(posedge rst_n);
        forever
        begin
            if (hold_long && !long_done)
            begin
                out_stall <= 1'b1;
                repeat (3000) @(posedge clk);
                long_done = 1;
            end
            n = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            out_stall <= (n > 0);
            repeat (n > 0 ? n : 1) @(posedge clk);
        end
    end

    // Count cycles with no accepted item and no taken result
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic idx, logic [SIZE_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one command, with an optional gap, and hold until taken
    task automatic send_command(cmd_t c, logic [31:0] k, logic [31:0] v, bit gaps);
        int n;
        n = gaps ? gap_len() : 0;
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{command: c, key: k, value: v};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending != 0)
            @(posedge clk);
        repeat (4200) @(posedge clk);
    endtask

    function automatic cmd_t pick_command();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return CMD_INSERT;
        if (r < 75) return CMD_SEARCH;
        if (r < 97) return CMD_ERASE;
        return CMD_NOP;
    endfunction

    task automatic random_phase(int count, int pool);
        logic [31:0] k;
        for (int i = 0; i < pool; i++)
            key_pool[i] = $urandom();
        for (int i = 0; i < count; i++)
        begin
            k = ($urandom_range(0, 9) == 0) ? $urandom() : key_pool[$urandom_range(0, pool - 1)];
            send_command(pick_command(), k, $urandom(), 1);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_MODE;
        cfg_data  = '0;
        hold_long = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extreme keys and values, every command, duplicates, misses
        send_command(CMD_SEARCH, 32'h0000_0000, 32'h0, 0);
        send_command(CMD_INSERT, 32'h0000_0000, 32'h8000_0000, 0);
        send_command(CMD_INSERT, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0);
        send_command(CMD_INSERT, 32'h8000_0000, 32'hFFFF_FFFF, 0);
        send_command(CMD_INSERT, 32'h7FFF_FFFF, 32'h0, 0);
        send_command(CMD_INSERT, 32'h7FFF_FFFF, 32'h1234_5678, 0);
        send_command(CMD_SEARCH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_command(CMD_SEARCH, 32'h7FFF_FFFF, 32'h0, 0);
        send_command(CMD_ERASE, 32'h8000_0000, 32'h0, 0);
        send_command(CMD_SEARCH, 32'h8000_0000, 32'h0, 0);
        send_command(CMD_ERASE, 32'h8000_0000, 32'h0, 0);
        send_command(CMD_INSERT, 32'h8000_0000, 32'h5555_AAAA, 0);
        send_command(CMD_NOP, 32'hDEAD_BEEF, 32'h1, 0);
        drain();

        // Tiny table: fill, overflow, full walks without empty slots
        write_reg(CFG_SIZE, 11'd2);
        for (int i = 0; i < 4; i++)
            send_command(CMD_INSERT, 32'h100 + i, i, 0);
        send_command(CMD_SEARCH, 32'h999, 0, 0);
        send_command(CMD_ERASE, 32'h999, 0, 0);
        drain();
        write_reg(CFG_SIZE, 11'd0);
        random_phase(30, 4);
        drain();

        // Phases across modes and sizes, extremes included
        write_reg(CFG_MODE, 1'b1);
        write_reg(CFG_SIZE, 11'd7);
        random_phase(200, 16);
        // Receiver holds off while the sender keeps offering
        hold_long = 1;
        random_phase(30, 8);
        drain();
        write_reg(CFG_SIZE, 11'd1024);
        random_phase(150, 16);
        drain();
        write_reg(CFG_SIZE, 11'd2047);
        random_phase(100, 16);
        drain();
        write_reg(CFG_MODE, 1'b0);
        write_reg(CFG_SIZE, 11'd31);
        random_phase(300, 16);
        drain();
        write_reg(CFG_SIZE, 11'd5);
        random_phase(300, 8);
        drain();
        write_reg(CFG_MODE, 1'b1);
        write_reg(CFG_SIZE, 11'd13);
        random_phase(300, 16);
        drain();
        write_reg(CFG_MODE, 1'b0);
        write_reg(CFG_SIZE, 11'd97);
        random_phase(370, 16);
        drain();

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
